// File: src/key_value_array_table_core_macros.svh
// assertion helpers for the key/value table
`ifndef KEY_VALUE_ARRAY_TABLE_CORE_MACROS_SVH
`define KEY_VALUE_ARRAY_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// checked at every edge outside reset
`define KVAT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define KVAT_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define KVAT_ASSERT(lbl, clk, rstn, prop, msg)
`define KVAT_ASSERT_NR(lbl, clk, prop, msg)

`endif

`endif

// File: src/kvat_pkg.sv
package kvat_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VAL_W    = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CAP_W    = 6;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  typedef enum logic [KIND_W-1:0] {
    KIND_SEARCH = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_DUPLICATE = 2'd3
  } status_e;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [VAL_W-1:0]        val_t;

  // one table slot as stored in memory
  typedef struct packed {
    key_t key;
    val_t value;
  } entry_t;

endpackage

// File: src/kvat_req_if.sv
interface kvat_req_if;
  import kvat_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  key_t              key;
  val_t              entry_value;

  modport source (output valid, kind, key, entry_value, input ready);
  modport sink (input valid, kind, key, entry_value, output ready);
endinterface

// File: src/kvat_rsp_if.sv
interface kvat_rsp_if;
  import kvat_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  val_t                found_value;

  modport source (output valid, status, found_value, input ready);
  modport sink (input valid, status, found_value, output ready);
endinterface

// File: src/kvat_ram.sv
module kvat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/key_value_array_table_core.sv
// key/value table: unsorted, densely packed slots with search, insert and delete
//
// channels: req_i (sink) carries kind, key and entry_value; rsp_o (source)
// carries status and found_value. a beat moves when valid and ready are high.
// cfg_we_i/cfg_data_i write the capacity register (slots usable, clipped to
// DEPTH); write it only while no request is in flight.
//
// each request is handled alone by a sequencer around one single-port-write,
// registered-read memory that holds key and value side by side. the scan
// reads one slot per cycle and compares it in the cycle after its read;
// delete then moves the later slots down one per cycle (read j+1, write j).
// ready is high only between requests; a finished response sits in the
// output register, so a new request is taken while the receiver stalls.
// reset empties the table (entry count zero), sets capacity to 32 and drops
// any pending response; memory contents are left as they are.
`include "key_value_array_table_core_macros.svh"

module key_value_array_table_core #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [kvat_pkg::CAP_W-1:0] cfg_data_i,
  kvat_req_if.sink                   req_i,
  kvat_rsp_if.source                 rsp_o
);
  import kvat_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned UW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [UW-1:0] DEPTH_U = UW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_e;

  // control state
  state_e             state_q, state_d;
  logic [CAP_W-1:0]   cap_q, cap_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      rd_idx_q, rd_idx_d;    // next slot to read
  logic [CW-1:0]      wr_idx_q, wr_idx_d;    // slot being refilled by the shift
  logic [CW-1:0]      lim_q, lim_d;          // slots visible to the scan
  logic               pend_q, pend_d;        // memory output holds a slot to compare
  logic               out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  val_t               out_found_q, out_found_d;

  // request payload and result under construction
  kind_e              kind_q, kind_d;
  key_t               key_q, key_d;
  val_t               val_q, val_d;
  status_e            res_status_q, res_status_d;
  val_t               res_found_q, res_found_d;

  // memory port
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  entry_t             mem_wdata;
  logic               mem_re;
  entry_t             mem_rdata;

  logic [UW-1:0]      usable_w;
  logic [CW-1:0]      usable_c;
  logic [CW-1:0]      lim_c;
  logic               hit;

  kvat_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  // usable size is capacity clipped to the built depth
  assign usable_w = (UW'(cap_q) > DEPTH_U) ? DEPTH_U : UW'(cap_q);
  assign usable_c = usable_w[CW-1:0];
  assign lim_c    = (usable_c < count_q) ? usable_c : count_q;

  assign hit = pend_q && (mem_rdata.key == key_q);

  assign mem_re = (state_q == S_SCAN) || (state_q == S_SHIFT);

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.found_value = out_found_q;

  always_comb begin
    state_d      = state_q;
    cap_d        = cfg_we_i ? cfg_data_i : cap_q;
    count_d      = count_q;
    rd_idx_d     = rd_idx_q;
    wr_idx_d     = wr_idx_q;
    lim_d        = lim_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    kind_d       = kind_q;
    key_d        = key_q;
    val_d        = val_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    mem_we       = 1'b0;
    mem_waddr    = wr_idx_q[AW-1:0];
    mem_wdata    = mem_rdata;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          kind_d       = kind_e'(req_i.kind);
          key_d        = req_i.key;
          val_d        = req_i.entry_value;
          rd_idx_d     = '0;
          pend_d       = 1'b0;
          lim_d        = lim_c;
          res_found_d  = '0;
          res_status_d = ST_DONE;
          case (kind_e'(req_i.kind))
            KIND_SEARCH, KIND_DELETE: begin
              state_d = S_SCAN;
            end
            KIND_INSERT: begin
              // full check comes before the duplicate scan
              if (usable_c <= count_q) begin
                res_status_d = ST_FULL;
                state_d      = S_FINISH;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: begin
              // unused kind: nothing changes
              state_d = S_FINISH;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          pend_d = 1'b0;
          case (kind_q)
            KIND_SEARCH: begin
              res_status_d = ST_DONE;
              res_found_d  = mem_rdata.value;
              state_d      = S_FINISH;
            end
            KIND_INSERT: begin
              res_status_d = ST_DUPLICATE;
              state_d      = S_FINISH;
            end
            KIND_DELETE: begin
              res_status_d = ST_DONE;
              if (rd_idx_q < count_q) begin
                // read of the slot after the match goes out this cycle
                wr_idx_d = rd_idx_q - CW'(1);
                rd_idx_d = rd_idx_q + CW'(1);
                state_d  = S_SHIFT;
              end else begin
                // match was the last used slot
                count_d = count_q - CW'(1);
                state_d = S_FINISH;
              end
            end
            default: begin
              state_d = S_FINISH;
            end
          endcase
        end else if (rd_idx_q < lim_q) begin
          pend_d   = 1'b1;
          rd_idx_d = rd_idx_q + CW'(1);
        end else begin
          // scan exhausted without a match
          pend_d  = 1'b0;
          state_d = S_FINISH;
          if (kind_q == KIND_INSERT) begin
            mem_we          = 1'b1;
            mem_waddr       = count_q[AW-1:0];
            mem_wdata.key   = key_q;
            mem_wdata.value = val_q;
            count_d         = count_q + CW'(1);
            res_status_d    = ST_DONE;
          end else begin
            res_status_d = ST_NOT_FOUND;
          end
        end
      end

      S_SHIFT: begin
        // memory output holds slot wr_idx + 1
        mem_we    = 1'b1;
        mem_waddr = wr_idx_q[AW-1:0];
        mem_wdata = mem_rdata;
        wr_idx_d  = wr_idx_q + CW'(1);
        if (rd_idx_q < count_q) begin
          rd_idx_d = rd_idx_q + CW'(1);
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_found_d  = res_found_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cap_q        <= CAP_RESET;
      count_q      <= '0;
      rd_idx_q     <= '0;
      wr_idx_q     <= '0;
      lim_q        <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_found_q  <= '0;
    end else begin
      state_q      <= state_d;
      cap_q        <= cap_d;
      count_q      <= count_d;
      rd_idx_q     <= rd_idx_d;
      wr_idx_q     <= wr_idx_d;
      lim_q        <= lim_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_found_q  <= out_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    key_q        <= key_d;
    val_q        <= val_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
  end

  `KVAT_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(DEPTH), "entry count above depth")
  `KVAT_ASSERT(a_shift_range, clk_i, rst_ni, (state_q == S_SHIFT) |-> ((wr_idx_q + CW'(1)) < count_q), "shift outside used slots")
  `KVAT_ASSERT(a_count_source, clk_i, rst_ni, (count_q != $past(count_q)) |-> (($past(state_q) == S_SCAN) || ($past(state_q) == S_SHIFT)), "entry count changed outside scan or shift")
  `KVAT_ASSERT(a_found_on_done, clk_i, rst_ni, (rsp_o.valid && (rsp_o.found_value != '0)) |-> (rsp_o.status == ST_DONE), "found value with failing status")
  `KVAT_ASSERT_NR(a_reset_quiet, clk_i, !rst_ni |-> ((state_q == S_IDLE) && !out_valid_q), "not idle in reset")

endmodule

// File: tb/key_value_array_table_core_tb.sv
`timescale 1ns / 1ps

module key_value_array_table_core_tb;
  import kvat_pkg::*;

  localparam int unsigned TBL_DEPTH = 32;
  localparam int unsigned POOL_N    = 40;
  localparam int unsigned MAX_GAP   = 19;

  // kind 3 has no operation behind it
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // one expected response beat
  typedef struct packed {
    status_e status;
    val_t    found;
  } table_rsp_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CAP_W-1:0] cfg_data_i;

  kvat_req_if req_if ();
  kvat_rsp_if rsp_if ();

  key_value_array_table_core #(
    .DEPTH (TBL_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // shadow copy of the table, updated as each request beat is accepted
  key_t             tbl_keys [TBL_DEPTH];
  val_t             tbl_vals [TBL_DEPTH];
  int               tbl_count;
  logic [CAP_W-1:0] tbl_cap;

  // responses still owed by the block, oldest first
  table_rsp_t       pending_rsp [$];
  table_rsp_t       due;

  key_t             key_pool [POOL_N];

  // idle switches for the request and response sides
  bit               req_gaps;
  bit               rsp_gaps;

  int               mismatches;
  int               sent;
  int               checked;
  int               cap_writes;
  int               status_seen [4];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout: %0d responses still pending", pending_rsp.size());
    $display("key_value_array_table_core_tb NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < 40) $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // predicted effect of one request on the shadow table
  function automatic table_rsp_t table_apply(input logic [KIND_W-1:0] kind, input key_t key,
                                             input val_t value);
    table_rsp_t r;
    int         usable;
    int         lim;
    int         pos;
    int         i;
    r.status = ST_DONE;
    r.found  = '0;
    usable   = (int'(tbl_cap) < TBL_DEPTH) ? int'(tbl_cap) : TBL_DEPTH;
    // only slots below both the usable size and the fill level are visible
    lim = (tbl_count < usable) ? tbl_count : usable;
    pos = -1;
    for (i = 0; i < lim; i++) begin
      if (pos < 0 && tbl_keys[i] == key) pos = i;
    end
    case (kind)
      KIND_SEARCH: begin
        if (pos < 0) r.status = ST_NOT_FOUND;
        else r.found = tbl_vals[pos];
      end
      KIND_INSERT: begin
        // full is checked ahead of the duplicate test
        if (usable <= tbl_count) begin
          r.status = ST_FULL;
        end else if (pos >= 0) begin
          r.status = ST_DUPLICATE;
        end else if (tbl_count < TBL_DEPTH) begin
          tbl_keys[tbl_count] = key;
          tbl_vals[tbl_count] = value;
          tbl_count++;
        end else begin
          r.status = ST_FULL;
        end
      end
      KIND_DELETE: begin
        if (pos < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          // shift covers every used slot, visible or not, and stops at the last one
          for (i = pos; (i + 1 < tbl_count) && (i + 1 < TBL_DEPTH); i++) begin
            tbl_keys[i] = tbl_keys[i+1];
            tbl_vals[i] = tbl_vals[i+1];
          end
          tbl_count--;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int unsigned draw_gap(input bit on);
    return on ? $urandom_range(MAX_GAP, 0) : 0;
  endfunction

  // one request beat; valid stays high when the next beat follows back to back
  task automatic send_req(input logic [KIND_W-1:0] kind, input key_t key, input val_t value);
    int unsigned gap;
    gap = draw_gap(req_gaps);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.kind        <= kind;
    req_if.key         <= key;
    req_if.entry_value <= value;
    do @(posedge clk_i); while (!req_if.ready);
    pending_rsp.push_back(table_apply(kind, key, value));
    sent++;
  endtask

  // drop valid and wait until every owed response has come back
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // capacity is only written with no request in flight
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= cap;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    tbl_cap = cap;
    cap_writes++;
  endtask

  // insert fresh keys until the table holds n entries
  task automatic fill_to(input int n);
    key_t k;
    bit   clash;
    int   i;
    while (tbl_count < n) begin
      do begin
        k     = key_t'($urandom);
        clash = 1'b0;
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_keys[i] == k) clash = 1'b1;
        end
      end while (clash);
      send_req(KIND_INSERT, k, val_t'($urandom_range(255, 0)));
    end
  endtask

  // delete whatever is stored, in random order
  task automatic empty_table();
    if (int'(tbl_cap) < tbl_count) set_capacity(CAP_RESET);
    while (tbl_count > 0) begin
      send_req(KIND_DELETE, tbl_keys[$urandom_range(tbl_count - 1, 0)],
               val_t'($urandom_range(255, 0)));
    end
  endtask

  // keys for a random phase: the extremes and a few edge values, random ones for the rest
  task automatic refresh_pool();
    int i;
    key_pool[0] = key_t'(32'h8000_0000);
    key_pool[1] = key_t'(32'h7fff_ffff);
    key_pool[2] = key_t'(32'h0000_0000);
    key_pool[3] = key_t'(32'hffff_ffff);
    key_pool[4] = key_t'(32'h0000_0001);
    for (i = 5; i < POOL_N; i++) key_pool[i] = key_t'($urandom);
  endtask

  // about 45% stored keys that hit, 40% pool keys, the rest anything; pool keys stand in when empty
  function automatic key_t draw_key();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 45 && tbl_count > 0) return tbl_keys[$urandom_range(tbl_count - 1, 0)];
    if (r < 85) return key_pool[$urandom_range(POOL_N - 1, 0)];
    return key_t'($urandom);
  endfunction

  // empty table right after reset, and the unused kind
  task automatic test_empty_after_reset();
    send_req(KIND_SEARCH, key_t'(32'h0000_0000), 8'h00);
    send_req(KIND_DELETE, key_t'(32'h7fff_ffff), 8'hff);
    send_req(KIND_UNUSED, key_t'(32'h8000_0000), 8'hff);
  endtask

  // insert, duplicate, search and delete with extreme keys and values
  task automatic test_basic_ops();
    empty_table();
    send_req(KIND_INSERT, key_t'(32'h8000_0000), 8'hff);
    send_req(KIND_INSERT, key_t'(32'h7fff_ffff), 8'h00);
    send_req(KIND_INSERT, key_t'(32'hffff_ffff), 8'ha5);
    send_req(KIND_INSERT, key_t'(32'h0000_0000), 8'h5a);
    send_req(KIND_INSERT, key_t'(32'h7fff_ffff), 8'h11);
    send_req(KIND_SEARCH, key_t'(32'h8000_0000), 8'h00);
    send_req(KIND_SEARCH, key_t'(32'h0000_0000), 8'h00);
    // middle delete, later entries move down
    send_req(KIND_DELETE, key_t'(32'h7fff_ffff), 8'h00);
    send_req(KIND_SEARCH, key_t'(32'hffff_ffff), 8'h00);
    send_req(KIND_SEARCH, key_t'(32'h7fff_ffff), 8'h00);
    // unused kind on a present key leaves the table alone
    send_req(KIND_UNUSED, key_t'(32'h0000_0000), 8'hff);
    send_req(KIND_SEARCH, key_t'(32'h0000_0000), 8'h00);
  endtask

  // all slots used: refusal, then deletes at the front, the back and the middle
  task automatic test_full_table();
    set_capacity(CAP_RESET);
    fill_to(TBL_DEPTH);
    send_req(KIND_INSERT, key_t'($urandom), 8'h3c);
    send_req(KIND_DELETE, tbl_keys[0], 8'h00);
    fill_to(TBL_DEPTH);
    send_req(KIND_DELETE, tbl_keys[TBL_DEPTH-1], 8'h00);
    fill_to(TBL_DEPTH);
    send_req(KIND_DELETE, tbl_keys[TBL_DEPTH/2], 8'h00);
    send_req(KIND_SEARCH, tbl_keys[TBL_DEPTH-2], 8'h00);
  endtask

  // capacity above the built depth is clipped
  task automatic test_capacity_clip();
    set_capacity(6'd63);
    fill_to(TBL_DEPTH);
    send_req(KIND_INSERT, key_t'($urandom), 8'hc3);
    send_req(KIND_SEARCH, tbl_keys[TBL_DEPTH-1], 8'h00);
    set_capacity(6'd40);
    send_req(KIND_INSERT, key_t'($urandom), 8'h81);
  endtask

  // zero capacity hides every slot
  task automatic test_capacity_zero();
    key_t held;
    empty_table();
    set_capacity(CAP_RESET);
    fill_to(2);
    held = tbl_keys[0];
    set_capacity(6'd0);
    send_req(KIND_INSERT, key_t'($urandom), 8'h7e);
    send_req(KIND_SEARCH, held, 8'h00);
    send_req(KIND_DELETE, held, 8'h00);
  endtask

  // capacity dropped under the fill level, then raised again
  task automatic test_capacity_lowered();
    key_t held [6];
    int   i;
    empty_table();
    set_capacity(CAP_RESET);
    fill_to(6);
    for (i = 0; i < 6; i++) held[i] = tbl_keys[i];
    set_capacity(6'd3);
    send_req(KIND_SEARCH, held[4], 8'h00);
    send_req(KIND_SEARCH, held[1], 8'h00);
    send_req(KIND_INSERT, held[0] ^ key_t'(32'h1), 8'h99);
    // the shift must also carry the hidden entries down
    send_req(KIND_DELETE, held[0], 8'h00);
    set_capacity(CAP_RESET);
    send_req(KIND_SEARCH, held[4], 8'h00);
    send_req(KIND_SEARCH, held[5], 8'h00);
  endtask

  task automatic run_random_phase(input logic [CAP_W-1:0] cap, input int unsigned n,
                                  input int unsigned ins_pct, input bit req_idle,
                                  input bit rsp_idle);
    int unsigned       r;
    logic [KIND_W-1:0] kind;
    set_capacity(cap);
    req_gaps = req_idle;
    rsp_gaps = rsp_idle;
    refresh_pool();
    repeat (n) begin
      r = $urandom_range(99, 0);
      if (r < 3) kind = KIND_UNUSED;
      else if (r < 3 + ins_pct) kind = KIND_INSERT;
      else if (r[0]) kind = KIND_SEARCH;
      else kind = KIND_DELETE;
      send_req(kind, draw_key(), val_t'($urandom_range(255, 0)));
    end
  endtask

  // phases carry the table over, so capacity changes land on filled tables
  task automatic test_random_traffic();
    run_random_phase(CAP_RESET, 250, 55, 1'b1, 1'b1);
    run_random_phase(6'd63, 200, 60, 1'b0, 1'b1);
    run_random_phase(6'd5, 150, 40, 1'b1, 1'b0);
    run_random_phase(6'd1, 100, 50, 1'b1, 1'b1);
    run_random_phase(6'd0, 40, 40, 1'b1, 1'b1);
    run_random_phase(6'd33, 200, 70, 1'b1, 1'b1);
    run_random_phase(6'd17, 150, 50, 1'b0, 1'b0);
    run_random_phase(6'd2, 100, 45, 1'b1, 1'b1);
    run_random_phase(CAP_W'($urandom_range(63, 0)), 100, 55, 1'b1, 1'b0);
    run_random_phase(CAP_W'($urandom_range(63, 0)), 100, 50, 1'b0, 1'b1);
  endtask

  // response side: random stall before each beat, ready held when none is drawn
  initial begin : rsp_stall
    int unsigned gap;
    rsp_if.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      gap = draw_gap(rsp_gaps);
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  // compare every response beat with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch($sformatf("response with none pending: status %0d value %0d",
                                  rsp_if.status, rsp_if.found_value));
      end else begin
        due = pending_rsp.pop_front();
        if (rsp_if.status !== due.status)
          report_mismatch($sformatf("status %0d, predicted %0d", rsp_if.status, due.status));
        if (rsp_if.found_value !== due.found)
          report_mismatch($sformatf("found_value %0d, predicted %0d",
                                    rsp_if.found_value, due.found));
        status_seen[due.status]++;
        checked++;
      end
    end
  end

  initial begin
    // every input known from time zero, reset held low before the tests start
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_data_i         <= CAP_RESET;
    req_if.valid       <= 1'b0;
    req_if.kind        <= KIND_SEARCH;
    req_if.key         <= '0;
    req_if.entry_value <= '0;
    tbl_count  = 0;
    tbl_cap    = CAP_RESET;
    req_gaps   = 1'b1;
    rsp_gaps   = 1'b1;
    mismatches = 0;
    sent       = 0;
    checked    = 0;
    cap_writes = 0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_after_reset();
    test_basic_ops();
    test_full_table();
    test_capacity_clip();
    test_capacity_zero();
    test_capacity_lowered();
    test_random_traffic();

    // drain, then give a late stray beat time to show up
    wait_idle();
    repeat (TBL_DEPTH + 8) @(posedge clk_i);
    if (pending_rsp.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", pending_rsp.size()));

    $display("covered %0d requests across %0d capacity writes, %0d responses checked",
             sent, cap_writes, checked);
    $display("outcomes: done %0d, not found %0d, full %0d, duplicate %0d",
             status_seen[ST_DONE], status_seen[ST_NOT_FOUND], status_seen[ST_FULL],
             status_seen[ST_DUPLICATE]);
    if (mismatches == 0) begin
      $display("key_value_array_table_core_tb OK");
    end else begin
      $display("key_value_array_table_core_tb NOT OK");
    end
    $finish;
  end

endmodule
